FILE: src/tgs_pkg.sv
// types and constants for the trilinear grid sampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tgs_pkg;
  localparam int GRID_CELLS = 32768;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIMS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORG_X = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORG_Y = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORG_Z = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_X = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_Y = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_Z = 3'd6;
  localparam logic [29:0] DIMS_RESET = 30'd2099202;
  localparam logic [23:0] INV_RESET = 24'd65536;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // per-axis mapping result
  typedef struct packed {
    logic [9:0]  lo;
    logic [9:0]  hi;
    logic [16:0] d;
  } axis_t;
endpackage
`default_nettype wire

FILE: src/trilinear_grid_sampler.sv
// trilinear grid sampler top level: grid memory, axis mapping, blend sequencer
// depends on tgs_pkg
`timescale 1ns / 1ps
`default_nettype none
// load: written while idle, the next request is taken right after
// query: steps map, address, read, blend, output in order (off mesh: map then output);
//   one query at a time, as in_stall stays high until the sequencer is idle again;
//   a stalled earlier result holds the output step
// reset clears control state, sets config defaults; grid memory contents stay undefined
module trilinear_grid_sampler import tgs_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_write,
  input  wire [CFG_IDX_BITS-1:0]   cfg_index,
  input  wire [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire                      command,
  input  wire [14:0]               sample_index,
  input  wire signed [31:0]        sample_value,
  input  wire signed [31:0]        point_x,
  input  wire signed [31:0]        point_y,
  input  wire signed [31:0]        point_z,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic signed [31:0]       interpolated_value,
  output logic                     on_mesh
);
  localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int VAW = 32 + 8;  // intermediate blend width, values never exceed inputs

  localparam logic [2:0] S_IDLE = 3'd0, S_MAP = 3'd1, S_ADDR = 3'd2,
                         S_READ = 3'd3, S_BLEND = 3'd4, S_OUT = 3'd5;

  logic [2:0] state;
  logic [29:0] dims;
  logic signed [31:0] org [3];
  logic [23:0] inv [3];
  logic signed [31:0] pt [3];
  axis_t ax [3];
  logic okall;
  logic [1:0] axc;
  logic [3:0] rd_cnt;
  logic rd_pend;
  logic [2:0] rd_tag;
  logic signed [VW-1:0] mem [GRID_CELLS];
  logic signed [VW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic signed [VAW-1:0] corner [8];
  logic [2:0] bl_cnt;

  wire [9:0] nx = dims[9:0];
  wire [9:0] ny = dims[19:10];
  wire [9:0] nz = dims[29:20];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= DIMS_RESET;
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
        inv[i] <= INV_RESET;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIMS:  dims <= cfg_data[29:0];
        REG_ORG_X: org[0] <= cfg_data;
        REG_ORG_Y: org[1] <= cfg_data;
        REG_ORG_Z: org[2] <= cfg_data;
        REG_INV_X: inv[0] <= cfg_data[23:0];
        REG_INV_Y: inv[1] <= cfg_data[23:0];
        REG_INV_Z: inv[2] <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // axis mapping of the axis under work (one multiplier shared by the three axes in turn)
  logic [9:0] n_sel;
  logic signed [32:0] diff;
  logic signed [57:0] prod;
  logic [41:0] ip;
  axis_t ax_new;
  always_comb begin
    unique case (axc)
      2'd0: n_sel = nx;
      2'd1: n_sel = ny;
      default: n_sel = nz;
    endcase
    diff = 33'(pt[axc]) - 33'(org[axc]);
    prod = 58'(diff) * $signed({34'd0, inv[axc]});
    ip = 42'(prod[57:32]);
    if (prod < 0) begin
      ax_new = '{lo: 10'd0, hi: 10'd1, d: 17'd0};
    end else if (ip >= 42'(n_sel - 10'd1)) begin
      ax_new = '{lo: n_sel - 10'd2, hi: n_sel - 10'd1, d: ONE_Q16};
    end else begin
      ax_new = '{lo: ip[9:0], hi: ip[9:0] + 10'd1, d: {1'b0, prod[31:16]}};
    end
  end

  // address partial terms, registered
  logic [19:0] y0nx, y1nx;
  logic [29:0] z0t, z1t;
  logic [19:0] nxny;

  // corner address: bit0 x, bit1 y, bit2 z
  always_comb begin
    logic [31:0] a;
    a = 32'(rd_cnt[0] ? ax[0].hi : ax[0].lo)
      + 32'(rd_cnt[1] ? y1nx : y0nx)
      + 32'(rd_cnt[2] ? z1t : z0t);
    rd_addr = a[AW-1:0];
  end

  // grid memory: loads write while idle, the read port is registered
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && command == CMD_LOAD) begin
      if (32'(sample_index) < 32'(GRID_CELLS))
        mem[sample_index[AW-1:0]] <= sample_value[VW-1:0];
    end
    rd_data <= mem[rd_addr];
  end

  // blend unit: a*(1-d) + b*d + half, floor shift
  logic signed [VAW-1:0] ba, bb;
  logic [16:0] bd;
  logic signed [VAW+18:0] bsum;
  logic signed [VAW-1:0] bres;
  always_comb begin
    unique case (bl_cnt)
      3'd0: begin ba = corner[0]; bb = corner[1]; bd = ax[0].d; end
      3'd1: begin ba = corner[2]; bb = corner[3]; bd = ax[0].d; end
      3'd2: begin ba = corner[4]; bb = corner[5]; bd = ax[0].d; end
      3'd3: begin ba = corner[6]; bb = corner[7]; bd = ax[0].d; end
      3'd4: begin ba = corner[0]; bb = corner[2]; bd = ax[1].d; end
      3'd5: begin ba = corner[4]; bb = corner[6]; bd = ax[1].d; end
      default: begin ba = corner[0]; bb = corner[4]; bd = ax[2].d; end
    endcase
    bsum = (VAW+19)'(ba) * $signed({1'b0, ONE_Q16 - bd})
         + (VAW+19)'(bb) * $signed({1'b0, bd}) + (VAW+19)'(32768);
    bres = VAW'(bsum >>> 16);
  end

  // saturation
  localparam logic signed [VAW-1:0] LIM_HI = VAW'((64'sd1 <<< (VW-1)) - 1);
  localparam logic signed [VAW-1:0] LIM_LO = -VAW'(64'sd1 <<< (VW-1));

  assign in_stall = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      axc <= '0;
      rd_cnt <= '0;
      rd_pend <= 1'b0;
      bl_cnt <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && command == CMD_QUERY) begin
            pt[0] <= point_x; pt[1] <= point_y; pt[2] <= point_z;
            axc <= '0;
            okall <= (nx >= 10'd2) && (ny >= 10'd2) && (nz >= 10'd2);
            state <= S_MAP;
          end
        end
        S_MAP: begin
          ax[axc] <= ax_new;
          if (axc == 2'd2) begin
            axc <= '0;
            state <= okall ? S_ADDR : S_OUT;
          end else begin
            axc <= axc + 2'd1;
          end
          nxny <= 20'(nx) * 20'(ny);
        end
        S_ADDR: begin
          y0nx <= 20'(ax[1].lo) * 20'(nx);
          y1nx <= 20'(ax[1].hi) * 20'(nx);
          z0t <= 30'(ax[2].lo) * 30'(nxny);
          z1t <= 30'(ax[2].hi) * 30'(nxny);
          rd_cnt <= '0;
          rd_pend <= 1'b0;
          state <= S_READ;
        end
        S_READ: begin
          rd_pend <= (rd_cnt < 4'd8);
          rd_tag <= rd_cnt[2:0];
          if (rd_pend) corner[rd_tag] <= VAW'(rd_data);
          if (rd_cnt < 4'd8) rd_cnt <= rd_cnt + 4'd1;
          else if (!rd_pend) begin
            bl_cnt <= '0;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          unique case (bl_cnt)
            3'd0: corner[0] <= bres;
            3'd1: corner[2] <= bres;
            3'd2: corner[4] <= bres;
            3'd3: corner[6] <= bres;
            3'd4: corner[0] <= bres;
            3'd5: corner[4] <= bres;
            default: corner[0] <= bres;
          endcase
          if (bl_cnt == 3'd6) state <= S_OUT;
          else bl_cnt <= bl_cnt + 3'd1;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            on_mesh <= okall;
            if (!okall) interpolated_value <= '0;
            else if (corner[0] > LIM_HI) interpolated_value <= 32'(LIM_HI);
            else if (corner[0] < LIM_LO) interpolated_value <= 32'(LIM_LO);
            else interpolated_value <= corner[0][31:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/tgs_checker.sv
// port-level checks for the trilinear grid sampler, bound to the top level
// depends on tgs_pkg
`timescale 1ns / 1ps
`default_nettype none
module tgs_checker import tgs_pkg::*; (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_stall,
  input wire command,
  input wire out_valid,
  input wire out_stall,
  input wire on_mesh,
  input wire [31:0] interpolated_value
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(interpolated_value))
    else $error("result changed under stall");
  // off mesh results are zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !on_mesh |-> interpolated_value == 32'd0)
    else $error("off mesh value not zero");
  // a load never makes a result
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_LOAD && !out_valid |=> !out_valid)
    else $error("result from load");
  // a query blocks new requests next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_QUERY |=> in_stall)
    else $error("request taken during query");
endmodule
bind trilinear_grid_sampler tgs_checker u_chk (.*);
`default_nettype wire
